/* src/nearest_free_cell_search_defines.svh */
// assertion macros for the top level rtl file
// depends on nothing; included by the top level
`ifndef NEAREST_FREE_CELL_SEARCH_DEFINES_SVH
`define NEAREST_FREE_CELL_SEARCH_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define NFCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define NFCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/nfcs_pkg.sv */
// package for the nearest free cell search block
// types, codes and cell constants; no dependencies
package nfcs_pkg;
    localparam logic [7:0] CELL_UNKNOWN  = 8'hFF;
    localparam logic [7:0] CELL_FREE     = 8'h00;
    localparam logic [7:0] CELL_OBSTACLE = 8'd100;

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CLEAR   = 2'd2;
    localparam logic [1:0] REG_RING    = 2'd3;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_CAND   = 10'b0000000100,
        S_CRD    = 10'b0000001000,
        S_CCHK   = 10'b0000010000,
        S_WIN    = 10'b0000100000,
        S_WRD    = 10'b0001000000,
        S_WCHK   = 10'b0010000000,
        S_NEXT   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;
endpackage

/* src/nearest_free_cell_search.sv */
// nearest free cell search: occupancy grid, ring scan sequencer, output register
// depends on nfcs_pkg, nfcs_ram and nearest_free_cell_search_defines.svh
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata {value,y,x}, tuser command
// m_axis    out  m_axis_tvalid/tready       tdata {y,x,status}
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a write beat is taken in S_IDLE; a query is accepted in S_IDLE, then each
// candidate cell passes S_CAND and S_NEXT when off the map, adds S_CRD and S_CCHK
// to read it, and when it is free adds S_WIN and an S_WRD/S_WCHK pair per window
// cell read through the single map ram port, then the result stage S_OUT
// after reset a clearing pass writes unknown to all DEPTH cells (65536 by default),
// one per cycle, before the first beat is taken
// the result register holds while m_axis stalls; the next beat is still taken and
// a finished query waits in the result stage until the register frees up
`include "nearest_free_cell_search_defines.svh"
module nearest_free_cell_search
    import nfcs_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cell_x[7:0], cell_y[15:8], cell_value[23:16]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], found_x[9:2], found_y[17:10], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    localparam int GRID_W = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
    localparam int GRID_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam int XB = $clog2(GRID_W);
    localparam int YB = $clog2(GRID_H);
    localparam int AB = XB + YB;
    localparam int DEPTH = 1 << AB;

    // signed coordinates, wide enough for q +- 2*255
    typedef logic signed [11:0] crd_t;

    state_t state_reg, state_next;
    logic [8:0] width_reg, height_reg;
    logic [7:0] clear_reg, ring_reg;
    logic [AB-1:0] clr_cnt_reg;

    logic [7:0] qx_reg, qy_reg;
    logic [8:0] r_reg;
    logic [1:0] phase_reg;      // 0 side columns, 2 top/bottom rows; side_reg picks the side
    logic       side_reg;
    crd_t       idx_reg;        // row in columns phase, column in rows phase
    crd_t       cx_reg, cy_reg;
    crd_t       wx_reg, wy_reg, wx1_reg, wy1_reg;

    // working result of the running query
    logic [1:0] res_status_reg;
    logic [7:0] res_x_reg, res_y_reg;

    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_x_reg, out_y_reg;

    // effective map size
    logic [8:0] eff_w, eff_h;
    assign eff_w = (width_reg  < 9'(GRID_W)) ? width_reg  : 9'(GRID_W);
    assign eff_h = (height_reg < 9'(GRID_H)) ? height_reg : 9'(GRID_H);

    logic [7:0] in_x, in_y, in_v;
    assign in_x = s_axis_tdata[7:0];
    assign in_y = s_axis_tdata[15:8];
    assign in_v = s_axis_tdata[23:16];
    logic in_inside;
    assign in_inside = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // result stage can hand over this cycle
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // candidate position for current ring/phase/index
    crd_t r_s, qx_s, qy_s, cand_x, cand_y;
    assign r_s  = crd_t'(r_reg);
    assign qx_s = crd_t'({1'b0, qx_reg});
    assign qy_s = crd_t'({1'b0, qy_reg});
    always_comb
    begin
        if (!phase_reg[1])
        begin
            cand_x = side_reg ? qx_s + r_s : qx_s - r_s;
            cand_y = idx_reg;
        end
        else
        begin
            cand_x = idx_reg;
            cand_y = side_reg ? qy_s + r_s : qy_s - r_s;
        end
    end
    logic cand_in;
    assign cand_in = !cand_x[11] && !cand_y[11] && (cand_x < crd_t'(eff_w))
                   && (cand_y < crd_t'(eff_h));

    // clipped window bounds
    crd_t d_s, wxa, wxb, wya, wyb;
    assign d_s = crd_t'({1'b0, clear_reg});
    always_comb
    begin
        wxa = cx_reg - d_s;
        if (wxa[11])
            wxa = '0;
        wxb = cx_reg + d_s;
        if (wxb > crd_t'(eff_w) - 12'sd1)
            wxb = crd_t'(eff_w) - 12'sd1;
        wya = cy_reg - d_s;
        if (wya[11])
            wya = '0;
        wyb = cy_reg + d_s;
        if (wyb > crd_t'(eff_h) - 12'sd1)
            wyb = crd_t'(eff_h) - 12'sd1;
    end

    // index end for current phase
    crd_t idx_end;
    assign idx_end = phase_reg[1] ? qx_s + r_s - 12'sd1 : qy_s + r_s;

    // ram port
    logic          ram_we;
    logic [AB-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = in_v;
        ram_addr  = {in_y[YB-1:0], in_x[XB-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = CELL_UNKNOWN;
                ram_addr  = clr_cnt_reg;
            end
            S_IDLE:
                ram_we = in_acc && (s_axis_tuser == CMD_WRITE) && in_inside;
            S_CAND, S_CRD, S_CCHK:
                ram_addr = {cy_reg[YB-1:0], cx_reg[XB-1:0]};
            default:
                ram_addr = {wy_reg[YB-1:0], wx_reg[XB-1:0]};
        endcase
    end

    nfcs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_cnt_reg == AB'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_acc && s_axis_tuser == CMD_QUERY)
                    state_next = (in_inside && ({1'b0, clear_reg} + 9'd1 <= {1'b0, ring_reg}))
                               ? S_CAND : S_OUT;
            S_CAND:   state_next = cand_in ? S_CRD : S_NEXT;
            S_CRD:    state_next = S_CCHK;
            S_CCHK:   state_next = (ram_rdata == CELL_FREE) ? S_WIN : S_NEXT;
            S_WIN:    state_next = S_WRD;
            S_WRD:    state_next = S_WCHK;
            S_WCHK:
                if (ram_rdata == CELL_OBSTACLE)
                    state_next = S_NEXT;
                else if (wy_reg == wy1_reg && wx_reg == wx1_reg)
                    state_next = S_OUT;
                else
                    state_next = S_WRD;
            S_NEXT:
                if (side_reg == 1'b0)
                    state_next = S_CAND;
                else if (idx_reg != idx_end)
                    state_next = S_CAND;
                else if (!phase_reg[1])
                    state_next = S_CAND;
                else if (r_reg[7:0] != ring_reg)
                    state_next = S_CAND;
                else
                    state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            clear_reg     <= 8'd6;
            ring_reg      <= 8'd20;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_CLEAR:  clear_reg  <= cfg_data[7:0];
                    REG_RING:   ring_reg   <= cfg_data[7:0];
                    default:    ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    qx_reg         <= in_x;
                    qy_reg         <= in_y;
                    r_reg          <= {1'b0, clear_reg} + 9'd1;
                    phase_reg      <= 2'd0;
                    side_reg       <= 1'b0;
                    idx_reg        <= crd_t'({1'b0, in_y}) - crd_t'({1'b0, clear_reg}) - 12'sd1;
                    res_x_reg      <= in_x;
                    res_y_reg      <= in_y;
                    res_status_reg <= in_inside ? ST_NONE : ST_OUTSIDE;
                end
            S_CAND:
            begin
                cx_reg <= cand_x;
                cy_reg <= cand_y;
            end
            S_CCHK:
            begin
                wx_reg  <= wxa;
                wx1_reg <= wxb;
                wy_reg  <= wya;
                wy1_reg <= wyb;
            end
            S_WCHK:
                if (wy_reg == wy1_reg)
                begin
                    wy_reg <= wya;
                    wx_reg <= wx_reg + 12'sd1;
                end
                else
                    wy_reg <= wy_reg + 12'sd1;
            S_NEXT:
                if (!side_reg)
                    side_reg <= 1'b1;
                else
                begin
                    side_reg <= 1'b0;
                    if (idx_reg != idx_end)
                        idx_reg <= idx_reg + 12'sd1;
                    else if (!phase_reg[1])
                    begin
                        phase_reg <= 2'd2;
                        idx_reg   <= qx_s - r_s + 12'sd1;
                    end
                    else
                    begin
                        phase_reg <= 2'd0;
                        r_reg     <= r_reg + 9'd1;
                        idx_reg   <= qy_s - r_s - 12'sd1;
                    end
                end
            default: ;
        endcase
        if (state_reg == S_WCHK && ram_rdata != CELL_OBSTACLE
            && wy_reg == wy1_reg && wx_reg == wx1_reg)
        begin
            res_status_reg <= ST_FOUND;
            res_x_reg      <= cx_reg[7:0];
            res_y_reg      <= cy_reg[7:0];
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_y_reg, out_x_reg, out_status_reg};

    // the window walk must stay inside the clipped window
    `NFCS_ASSERT_IMP(a_win_bounds, state_reg == S_WCHK, wx_reg <= wx1_reg && wy_reg <= wy1_reg, "window walk out of bounds")
    // no beat is taken during the clearing pass
    `NFCS_ASSERT_IMP(a_no_accept_clear, state_reg == S_CLEAR, !s_axis_tready, "beat taken while clearing")
    // a stalled result keeps its payload
    `NFCS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    // a found result always lies inside the map width
    `NFCS_ASSERT_IMP(a_found_inside, m_axis_tvalid && m_axis_tdata[1:0] == ST_FOUND, 9'(m_axis_tdata[9:2]) < eff_w, "found cell outside map")
endmodule

/* src/nfcs_ram.sv */
// generic single port ram with registered read
// no dependencies
module nfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* sim/tb_nearest_free_cell_search.sv */
// testbench for nearest_free_cell_search: grid writes, ring-scan queries, config
// depends on nfcs_pkg and the nearest_free_cell_search rtl; self-checking, no files
`timescale 1ns / 100ps
module tb_nearest_free_cell_search
    import nfcs_pkg::*;
();

    localparam int GRID      = 256;
    localparam int IDLE_MAX  = 400000;  // watchdog limit, covers the clearing pass
    localparam int SETTLE    = 40;      // cycles for a last cell write to land

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] x;
        logic [7:0] y;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // cell_x[7:0], cell_y[15:8], cell_value[23:16]
    logic        s_axis_tuser;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status[1:0], found_x[9:2], found_y[17:10], zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    // shadow of the grid and registers, updated as beats are accepted
    logic [7:0]  grid_shadow [0:GRID*GRID-1];
    logic [8:0]  cols_cfg;
    logic [8:0]  rows_cfg;
    logic [7:0]  clear_cfg;
    logic [7:0]  ring_cfg;

    answer_t     pending_answers[$];
    int          mismatches;
    int          idle_cycles;
    bit          quiet_sender;
    bit          quiet_receiver;
    bit          hold_request;
    int          hold_left;

    nearest_free_cell_search DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // true when the clipped square of half side d around (x,y) has no obstacle
    function automatic bit window_free(int x, int y, int d, int w, int h);
        int x0;
        int x1;
        int y0;
        int y1;
        x0 = (x - d < 0) ? 0 : x - d;
        x1 = (x + d > w - 1) ? w - 1 : x + d;
        y0 = (y - d < 0) ? 0 : y - d;
        y1 = (y + d > h - 1) ? h - 1 : y + d;
        for (int i = x0; i <= x1; i++)
            for (int j = y0; j <= y1; j++)
                if (grid_shadow[j*GRID + i] == CELL_OBSTACLE)
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit usable_cell(int x, int y, int d, int w, int h);
        if (x < 0 || x >= w || y < 0 || y >= h)
            return 1'b0;
        return grid_shadow[y*GRID + x] == CELL_FREE && window_free(x, y, d, w, h);
    endfunction

    // ring scan: left/right columns row by row, then top/bottom rows
    function automatic answer_t nearest_free(int qx, int qy);
        answer_t a;
        int w;
        int h;
        int d;
        w = (int'(cols_cfg) < GRID) ? int'(cols_cfg) : GRID;
        h = (int'(rows_cfg) < GRID) ? int'(rows_cfg) : GRID;
        d = int'(clear_cfg);
        a.x = qx[7:0];
        a.y = qy[7:0];
        if (!(qx < w && qy < h))
        begin
            a.status = ST_OUTSIDE;
            return a;
        end
        a.status = ST_NONE;
        for (int r = d + 1; r <= int'(ring_cfg); r++)
        begin
            for (int i = qy - r; i <= qy + r; i++)
            begin
                if (usable_cell(qx - r, i, d, w, h))
                    return '{ST_FOUND, 8'(qx - r), 8'(i)};
                if (usable_cell(qx + r, i, d, w, h))
                    return '{ST_FOUND, 8'(qx + r), 8'(i)};
            end
            for (int j = qx - r + 1; j < qx + r; j++)
            begin
                if (usable_cell(j, qy - r, d, w, h))
                    return '{ST_FOUND, 8'(j), 8'(qy - r)};
                if (usable_cell(j, qy + r, d, w, h))
                    return '{ST_FOUND, 8'(j), 8'(qy + r)};
            end
        end
        return a;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offers one beat and leaves tvalid high; callers lower it via wait_idle
    task automatic send_beat(logic cmd, logic [7:0] x, logic [7:0] y, logic [7:0] val);
        int gap;
        if (!quiet_sender && $urandom_range(0, 99) < 8)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, y, x};
        do @(posedge clk); while (!s_axis_tready);
        if (cmd == CMD_QUERY)
            pending_answers.push_back(nearest_free(int'(x), int'(y)));
        else if (x < cols_cfg && y < rows_cfg)
            grid_shadow[y*GRID + x] = val;
    endtask

    task automatic put_cell(int x, int y, logic [7:0] val);
        send_beat(CMD_WRITE, x[7:0], y[7:0], val);
    endtask

    task automatic ask(int x, int y);
        send_beat(CMD_QUERY, x[7:0], y[7:0], 8'($urandom_range(0, 255)));
    endtask

    // stop offering, let every expected result arrive, then let writes settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH:  cols_cfg  = val;
            REG_HEIGHT: rows_cfg  = val;
            REG_CLEAR:  clear_cfg = val[7:0];
            REG_RING:   ring_cfg  = val[7:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_map(int w, int h, int d, int r);
        wait_idle();
        write_reg(REG_WIDTH, w[8:0]);
        write_reg(REG_HEIGHT, h[8:0]);
        write_reg(REG_CLEAR, d[8:0]);
        write_reg(REG_RING, r[8:0]);
    endtask

    // ---------------------------------------------------------------
    // receiver and checker
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // long hold-offs are counted here, short random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end
        else if (hold_request && hold_left == 0)
        begin
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 1)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            hold_left     <= 0;
            m_axis_tready <= quiet_receiver || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[17:10]};
            if (pending_answers.size() == 0)
                report_mismatch("unexpected beat, status", int'(got.status), -1);
            else
            begin
                want = pending_answers.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.x != want.x)
                    report_mismatch("found_x", int'(got.x), int'(want.x));
                if (got.y != want.y)
                    report_mismatch("found_y", int'(got.y), int'(want.y));
            end
        end
    end

    // watchdog: cycles without any accepted beat on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("FAIL nearest_free_cell_search");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // zero, oversize, single-row and single-column maps, writes outside the map
    task automatic test_map_size();
        set_map(0, 0, 0, 0);
        ask(5, 5);                       // every cell outside
        put_cell(0, 0, CELL_FREE);       // ignored
        set_map(511, 1, 0, 3);           // width clamps to 256
        ask(255, 0);
        ask(3, 1);                       // row outside
        put_cell(2, 1, CELL_FREE);       // outside, must not land
        put_cell(255, 0, CELL_FREE);
        ask(253, 0);
        set_map(1, 256, 0, 2);
        put_cell(0, 255, CELL_FREE);
        ask(0, 254);
        ask(1, 0);
    endtask

    // obstacle inside the clearance square, odd cell values, grid corners
    task automatic test_cell_values();
        set_map(16, 16, 1, 4);
        put_cell(5, 3, CELL_FREE);
        put_cell(6, 3, CELL_OBSTACLE);   // blocks (5,3) at clearance 1
        put_cell(3, 5, CELL_FREE);
        put_cell(3, 6, 8'h7F);           // not an obstacle
        put_cell(3, 4, 8'h80);
        ask(5, 5);
        put_cell(3, 5, CELL_UNKNOWN);
        ask(5, 5);
        set_map(256, 256, 0, 255);
        put_cell(254, 254, CELL_FREE);
        put_cell(1, 0, CELL_FREE);
        ask(255, 255);
        ask(0, 0);
        set_map(256, 256, 255, 255);     // first ring beyond the last
        ask(100, 100);
        set_map(256, 256, 254, 255);
        ask(0, 0);                       // ring 255 only, partly inside the map
    endtask

    // receiver holds off while queries keep coming, then the sender waits
    task automatic test_backpressure();
        set_map(12, 12, 0, 3);
        quiet_sender = 1'b1;
        put_cell(4, 4, CELL_FREE);
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++)
            ask($urandom_range(0, 13), $urandom_range(0, 13));
        hold_request = 1'b0;
        wait_idle();
        quiet_sender = 1'b0;
    endtask

    task automatic random_beat(int w, int h);
        int roll;
        logic [7:0] val;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 6))
            0, 1, 2: val = CELL_FREE;
            3:       val = CELL_OBSTACLE;
            4:       val = CELL_UNKNOWN;
            default: val = 8'($urandom_range(0, 255));
        endcase
        if (roll < 10)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (roll < 40)
            ask($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        else
            put_cell($urandom_range(0, w - 1), $urandom_range(0, h - 1), val);
    endtask

    // small maps and short scans, alternating with wide or tall maps
    task automatic test_random_traffic();
        int w;
        int h;
        int d;
        for (int phase = 0; phase < 7; phase++)
        begin
            w = (phase % 3 == 2) ? $urandom_range(200, 256) : $urandom_range(4, 32);
            h = (phase % 3 == 1) ? $urandom_range(200, 256) : $urandom_range(4, 32);
            d = $urandom_range(0, 2);
            set_map(w, h, d, (phase == 4) ? 0 : d + $urandom_range(1, 4));
            quiet_sender   = (phase == 3);
            quiet_receiver = (phase == 3);
            for (int n = 0; n < 80; n++)
                random_beat(w, h);
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatches     = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        hold_request   = 1'b0;
        cols_cfg       = 9'd256;
        rows_cfg       = 9'd256;
        clear_cfg      = 8'd6;
        ring_cfg       = 8'd20;
        for (int i = 0; i < GRID*GRID; i++)
            grid_shadow[i] = CELL_UNKNOWN;
        repeat (4) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_map_size();
        test_cell_values();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0)
            $display("PASS nearest_free_cell_search");
        else
            $display("FAIL nearest_free_cell_search");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/nfcs_pkg.sv
src/nfcs_ram.sv
src/nearest_free_cell_search.sv
sim/tb_nearest_free_cell_search.sv
